// File: sv/vbd_pkg.sv
// Package for the velocity beat detector: field widths, reset values,
// detector state encoding. No dependencies.
`default_nettype none

package vbd_pkg;

    localparam int unsigned POS_W    = 8;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned VEL_W    = 9;
    localparam int unsigned BEAT_W   = 16;
    localparam int unsigned KEY_W    = 9;
    localparam int unsigned THR_W    = 6;
    localparam int unsigned HOLD_W   = 10;
    localparam int unsigned CFG_W    = 10;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [THR_W-1:0]  THR_RESET  = 6'd4;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 10'd75;
    localparam logic [KEY_W-1:0]  NOTE_OFFSET = 9'd30;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF   = 1'b1;

    // warmup progress
    typedef enum logic [1:0] {
        WARM_EMPTY = 2'd0,
        WARM_ONE   = 2'd1,
        WARM_DONE  = 2'd2
    } t_warm;

    // detector state; BEAT is only reported, never held
    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_ARMED   = 2'd1,
        MODE_BEAT    = 2'd2,
        MODE_HOLDOFF = 2'd3
    } t_mode;

endpackage

`default_nettype wire

// File: sv/vbd_in_if.sv
// Input channel of the beat detector: valid/ready plus one sample.
// Depends on vbd_pkg.
`default_nettype none

interface vbd_in_if;
    logic                        valid;
    logic                        ready;
    logic [vbd_pkg::POS_W-1:0]   position;
    logic [vbd_pkg::TIME_W-1:0]  time_ms;

    modport source (output valid, output position, output time_ms, input ready);
    modport sink   (input valid, input position, input time_ms, output ready);
endinterface

`default_nettype wire

// File: sv/vbd_out_if.sv
// Result channel of the beat detector: valid/ready plus one result.
// Depends on vbd_pkg.
`default_nettype none

interface vbd_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [vbd_pkg::VEL_W-1:0] velocity;
    logic [1:0]                       detector_state;
    logic                             beat_seen;
    logic [vbd_pkg::BEAT_W-1:0]       beat_number;
    logic signed [vbd_pkg::KEY_W-1:0] note_key;

    modport source (output valid, output velocity, output detector_state,
                    output beat_seen, output beat_number, output note_key,
                    input ready);
    modport sink   (input valid, input velocity, input detector_state,
                    input beat_seen, input beat_number, input note_key,
                    output ready);
endinterface

`default_nettype wire

// File: sv/velocity_beat_detector_top.sv
// A sample passes through the input register, then the result register.
// One sample per cycle when the result channel does not stall; the detector
// state, warmup count and history update as a sample leaves the input register.
// The first two samples after reset produce no result.
// Reset (i_rst_n low, synchronous): pipeline empty, state idle, beat count 1,
// threshold 4, holdoff 75 ms.
`default_nettype none

module velocity_beat_detector_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    vbd_in_if.sink                                 i_in,
    vbd_out_if.source                              o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [vbd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [vbd_pkg::CFG_W-1:0]         i_cfg_data
);

    // configuration
    logic [vbd_pkg::THR_W-1:0]  r_threshold;
    logic [vbd_pkg::HOLD_W-1:0] r_holdoff;

    // input register
    logic                        r_s1_valid;
    logic [vbd_pkg::POS_W-1:0]   r_s1_pos;
    logic [vbd_pkg::TIME_W-1:0]  r_s1_time;

    // detector state
    logic [vbd_pkg::POS_W-1:0]         r_prev_pos;
    logic signed [vbd_pkg::VEL_W-1:0]  r_prev_vel;
    vbd_pkg::t_warm                    r_warm;
    vbd_pkg::t_mode                    r_mode;
    logic [vbd_pkg::TIME_W-1:0]        r_arm_time;
    logic [vbd_pkg::BEAT_W-1:0]        r_beat_cnt;

    // result register
    logic                              r_out_valid;
    logic signed [vbd_pkg::VEL_W-1:0]  r_out_vel;
    vbd_pkg::t_mode                    r_out_state;
    logic                              r_out_beat;
    logic [vbd_pkg::BEAT_W-1:0]        r_out_num;
    logic signed [vbd_pkg::KEY_W-1:0]  r_out_key;

    logic                              out_free;
    logic                              advance;
    logic                              emit;
    logic signed [vbd_pkg::VEL_W-1:0]  vel;
    logic [vbd_pkg::TIME_W-1:0]        elapsed;
    vbd_pkg::t_mode                    n_mode;
    vbd_pkg::t_mode                    report;
    logic                              beat;
    logic                              arm;

    assign out_free   = !r_out_valid || o_out.ready;
    assign advance    = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;
    assign emit       = advance && (r_warm == vbd_pkg::WARM_DONE);

    assign vel     = $signed({1'b0, r_s1_pos}) - $signed({1'b0, r_prev_pos});
    assign elapsed = r_s1_time - r_arm_time;

    always_comb begin
        n_mode = r_mode;
        report = vbd_pkg::MODE_IDLE;
        beat   = 1'b0;
        arm    = 1'b0;
        unique case (r_mode)
            vbd_pkg::MODE_HOLDOFF: begin
                if (elapsed > {{(vbd_pkg::TIME_W-vbd_pkg::HOLD_W){1'b0}}, r_holdoff}) begin
                    n_mode = vbd_pkg::MODE_IDLE;
                    report = vbd_pkg::MODE_IDLE;
                end else begin
                    report = vbd_pkg::MODE_HOLDOFF;
                end
            end
            vbd_pkg::MODE_ARMED: begin
                if (vel < r_prev_vel) begin
                    beat   = 1'b1;
                    n_mode = vbd_pkg::MODE_HOLDOFF;
                    report = vbd_pkg::MODE_BEAT;
                end else begin
                    report = vbd_pkg::MODE_ARMED;
                end
            end
            vbd_pkg::MODE_IDLE, vbd_pkg::MODE_BEAT: begin
                // the beat code is never held; treat it as idle
                if (vel > $signed({{(vbd_pkg::VEL_W-vbd_pkg::THR_W){1'b0}}, r_threshold})) begin
                    arm    = 1'b1;
                    n_mode = vbd_pkg::MODE_ARMED;
                    report = vbd_pkg::MODE_ARMED;
                end else begin
                    n_mode = vbd_pkg::MODE_IDLE;
                    report = vbd_pkg::MODE_IDLE;
                end
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= vbd_pkg::THR_RESET;
            r_holdoff   <= vbd_pkg::HOLD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vbd_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data[vbd_pkg::THR_W-1:0];
                vbd_pkg::CFG_HOLDOFF:   r_holdoff   <= i_cfg_data[vbd_pkg::HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_pos  <= i_in.position;
            r_s1_time <= i_in.time_ms;
        end
    end

    // detector state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pos <= '0;
            r_prev_vel <= '0;
            r_warm     <= vbd_pkg::WARM_EMPTY;
            r_mode     <= vbd_pkg::MODE_IDLE;
            r_arm_time <= '0;
            r_beat_cnt <= {{(vbd_pkg::BEAT_W-1){1'b0}}, 1'b1};
        end else if (advance) begin
            r_prev_pos <= r_s1_pos;
            unique case (r_warm)
                vbd_pkg::WARM_EMPTY: r_warm <= vbd_pkg::WARM_ONE;
                vbd_pkg::WARM_ONE: begin
                    r_warm     <= vbd_pkg::WARM_DONE;
                    r_prev_vel <= vel;
                end
                default: begin
                    r_prev_vel <= vel;
                    r_mode     <= n_mode;
                    if (arm) begin
                        r_arm_time <= r_s1_time;
                    end
                    if (beat) begin
                        r_beat_cnt <= r_beat_cnt + 1'b1;
                    end
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_vel   <= vel;
            r_out_state <= report;
            r_out_beat  <= beat;
            r_out_num   <= beat ? r_beat_cnt : '0;
            r_out_key   <= beat ? ($signed({1'b0, r_s1_pos}) - $signed(vbd_pkg::NOTE_OFFSET))
                                : '0;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.velocity       = r_out_vel;
    assign o_out.detector_state = r_out_state;
    assign o_out.beat_seen      = r_out_beat;
    assign o_out.beat_number    = r_out_num;
    assign o_out.note_key       = r_out_key;

endmodule

`default_nettype wire

// File: sv/vbd_checker.sv
// Port-level checks for velocity_beat_detector_top, attached by bind.
// Depends on vbd_pkg and the top level's result channel.
`default_nettype none

module vbd_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_valid,
    input wire logic                              i_ready,
    input wire logic signed [vbd_pkg::VEL_W-1:0]  i_velocity,
    input wire logic [1:0]                        i_state,
    input wire logic                              i_beat,
    input wire logic [vbd_pkg::BEAT_W-1:0]        i_number,
    input wire logic signed [vbd_pkg::KEY_W-1:0]  i_key
);

    // no beat: number and key read as zero
    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_beat) |-> (i_number == '0 && i_key == '0))
        else $error("beat fields nonzero without a beat");

    // beat flag and reported state agree
    a_beat_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_beat == (i_state == vbd_pkg::MODE_BEAT)))
        else $error("beat flag disagrees with detector state");

    // velocity of two 8-bit positions never reaches -256
    a_vel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_velocity != -9'sd256))
        else $error("velocity out of range");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_velocity) && $stable(i_state)
                                   && $stable(i_number)))
        else $error("stalled result changed");

endmodule

bind velocity_beat_detector_top vbd_checker u_vbd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (o_out.valid),
    .i_ready    (o_out.ready),
    .i_velocity (o_out.velocity),
    .i_state    (o_out.detector_state),
    .i_beat     (o_out.beat_seen),
    .i_number   (o_out.beat_number),
    .i_key      (o_out.note_key)
);

`default_nettype wire
